@@ hw/rtl/ilp_pkg.sv @@
`default_nettype none

package ilp_pkg;

  // Default widths of the result value and of the internal character count.
  localparam int VALUE_BITS_DEF  = 64;
  localparam int LENGTH_BITS_DEF = 8;

  // Width of the length field on the result port.
  localparam int LEN_PORT_W = 8;

  // Width of the kind field and its codes.
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX  = 2'd2;

  // Characters that steer the parse.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // Offset from a letter digit to its value: 'a' stands for ten.
  localparam logic [7:0] HEX_LETTER_OFS = 8'd10;

endpackage

`default_nettype wire

@@ hw/rtl/integer_literal_parser.sv @@
`default_nettype none

// Channel  | Direction | Ports                                  | Meaning
// ---------+-----------+----------------------------------------+---------------------------------
// in       | input     | in_valid, in_ready, in_ch, in_first    | one character, start-of-literal
// out      | output    | out_valid, out_ready, out_value,       | one parsed literal
//          |           | out_length, out_kind                   |
//
// Each accepted character beat is registered in the input register; a literal's result is
// registered in the result register. The block takes one character per clock unless stalled.
// The parse itself (shift-add by ten or shift by four, count and phase update) is one short
// combinational step between the input register and the parse state registers.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to idle.
// A literal-ending character waits in the input register only while the result register is
// full and not being taken; characters that end nothing pass on regardless.
module integer_literal_parser #(
  parameter int VALUE_BITS  = ilp_pkg::VALUE_BITS_DEF,
  parameter int LENGTH_BITS = ilp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_ch,
  input  wire logic                           in_first,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [VALUE_BITS-1:0]               out_value,
  output logic [ilp_pkg::LEN_PORT_W-1:0]      out_length,
  output logic [ilp_pkg::KIND_W-1:0]          out_kind
);

  import ilp_pkg::*;

  // Parse phases.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_DEC  = 3'd3;
  localparam logic [2:0] PH_HEXP = 3'd4;
  localparam logic [2:0] PH_HEX  = 3'd5;

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);

  // Input register.
  logic                    in_vld_r;
  logic [7:0]              in_ch_r;
  logic                    in_first_r;

  // Parse state.
  logic [2:0]              phase_r, phase_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0]  cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;

  // Result register.
  logic                    out_vld_r;
  logic [VALUE_BITS-1:0]   out_value_r, emit_value;
  logic [LEN_PORT_W-1:0]   out_length_r, emit_length;
  logic [KIND_W-1:0]       out_kind_r, emit_kind;

  logic                    emit;
  logic                    adv;
  logic                    out_free;
  logic                    is_dec, is_hex, is_x;
  logic [3:0]              dec_val, hex_val;
  logic [LENGTH_BITS-1:0]  cnt_bump;
  logic [VALUE_BITS-1:0]   acc_x10, acc_x16;

  // Digit decode of the registered character. Bytes from 128 upwards never match.
  always_comb begin
    is_dec  = (in_ch_r >= CH_ZERO) && (in_ch_r <= CH_NINE);
    dec_val = 4'(in_ch_r - CH_ZERO);
    is_x    = (in_ch_r == CH_LO_X) || (in_ch_r == CH_UP_X);
    if (is_dec) begin
      is_hex  = 1'b1;
      hex_val = dec_val;
    end else if ((in_ch_r >= CH_LO_A) && (in_ch_r <= CH_LO_F)) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_ch_r - CH_LO_A + HEX_LETTER_OFS);
    end else if ((in_ch_r >= CH_UP_A) && (in_ch_r <= CH_UP_F)) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_ch_r - CH_UP_A + HEX_LETTER_OFS);
    end else begin
      is_hex  = 1'b0;
      hex_val = 4'd0;
    end
  end

  // Multiply by ten as two shifts and an add; both products wrap at the value width.
  assign acc_x10  = (acc_r << 3) + (acc_r << 1) + VALUE_BITS'(dec_val);
  assign acc_x16  = (acc_r << 4) | VALUE_BITS'(hex_val);
  assign cnt_bump = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + CNT_ONE;

  // One parse step for the character in the input register.
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    neg_nxt     = neg_r;
    emit        = 1'b0;
    emit_value  = '0;
    emit_length = '0;
    emit_kind   = KIND_NONE;
    if (in_first_r) begin
      // A start flag always opens a fresh literal, dropping any open one.
      acc_nxt = '0;
      neg_nxt = 1'b0;
      cnt_nxt = CNT_ONE;
      if (in_ch_r == CH_MINUS) begin
        neg_nxt   = 1'b1;
        phase_nxt = PH_SIGN;
      end else if (in_ch_r == CH_ZERO) begin
        phase_nxt = PH_ZERO;
      end else if (is_dec) begin
        acc_nxt   = VALUE_BITS'(dec_val);
        phase_nxt = PH_DEC;
      end else begin
        // Not a number at all: an empty result straight away.
        cnt_nxt   = '0;
        phase_nxt = PH_IDLE;
        emit      = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_SIGN: begin
          if (is_dec) begin
            acc_nxt   = VALUE_BITS'(dec_val);
            cnt_nxt   = cnt_bump;
            phase_nxt = PH_DEC;
          end else begin
            // A lone minus sign is no number.
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
          end
        end
        PH_ZERO: begin
          if (is_dec) begin
            acc_nxt   = VALUE_BITS'(dec_val);
            cnt_nxt   = cnt_bump;
            phase_nxt = PH_DEC;
          end else if (is_x) begin
            cnt_nxt   = cnt_bump;
            phase_nxt = PH_HEXP;
          end else begin
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            emit_length = LEN_PORT_W'(1);
            emit_kind   = KIND_DEC;
          end
        end
        PH_DEC: begin
          if (is_dec) begin
            acc_nxt = acc_x10;
            cnt_nxt = cnt_bump;
          end else begin
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            emit_value  = neg_r ? (VALUE_BITS'(0) - acc_r) : acc_r;
            emit_length = LEN_PORT_W'(cnt_r);
            emit_kind   = KIND_DEC;
          end
        end
        PH_HEXP: begin
          if (is_hex) begin
            acc_nxt   = VALUE_BITS'(hex_val);
            cnt_nxt   = cnt_bump;
            phase_nxt = PH_HEX;
          end else begin
            // The prefix had no digits: it stands as the decimal zero alone.
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            emit_length = LEN_PORT_W'(1);
            emit_kind   = KIND_DEC;
          end
        end
        PH_HEX: begin
          if (is_hex) begin
            acc_nxt = acc_x16;
            cnt_nxt = cnt_bump;
          end else begin
            phase_nxt   = PH_IDLE;
            emit        = 1'b1;
            emit_value  = acc_r;
            emit_length = LEN_PORT_W'(cnt_r);
            emit_kind   = KIND_HEX;
          end
        end
        default: begin
          // Idle: characters between literals are dropped.
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // The character in the input register moves on unless it ends a literal while the result
  // register is still held by the consumer.
  assign out_free = !out_vld_r || out_ready;
  assign adv      = in_vld_r && (out_free || !emit);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_ch_r    <= in_ch;
      in_first_r <= in_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_value_r  <= emit_value;
      out_length_r <= emit_length;
      out_kind_r   <= emit_kind;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_value  = out_value_r;
  assign out_length = out_length_r;
  assign out_kind   = out_kind_r;

`ifndef NO_ASSERTIONS
  // A literal that produced a result leaves the parser idle.
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit |=> phase_r == PH_IDLE)
    else $error("parser not idle after a result");

  // An empty result carries neither value nor length.
  a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_kind_r == KIND_NONE |-> out_value_r == '0 && out_length_r == '0)
    else $error("empty result with a value or length");

  // A held character is neither lost nor altered while it waits for the result register.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_ch_r) && $stable(in_first_r))
    else $error("stalled character lost");
`endif

endmodule

`default_nettype wire
